// ===== hdl/keyed_running_stats_table_defines.svh =====
// Assertion helpers for the statistics table. Both expect clk and arst_n in scope.
`ifndef KEYED_RUNNING_STATS_TABLE_DEFINES_SVH
`define KEYED_RUNNING_STATS_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define KRST_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("krst assertion failed");
// The expression must never be true outside reset.
`define KRST_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("krst forbidden condition seen");
`else
`define KRST_ASSERT(lbl, prop)
`define KRST_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/krst_pkg.sv =====
package krst_pkg;

	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  arch;
		logic [31:0] footprint;
		logic [31:0] data_size;
		logic [31:0] measured;
	} krst_cmd_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] mean;
		logic [31:0] deviation;
		logic [31:0] samples;
		logic        table_full;
	} krst_rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] size;
		logic [31:0] count;
		logic [63:0] sum;
		logic [63:0] sumsq;
	} krst_entry_t;

	typedef struct packed {
		logic [31:0] count;
		logic [63:0] sum;
		logic [63:0] sumsq;
	} krst_stats_arg_t;

	typedef struct packed {
		logic        done;
		logic [31:0] mean;
		logic [31:0] dev;
	} krst_stats_res_t;

	typedef struct packed {
		logic         go;
		logic         wide;
		logic [127:0] num;
		logic [31:0]  den;
	} krst_div_req_t;

	typedef struct packed {
		logic        done;
		logic        qhi;
		logic [63:0] quot;
	} krst_div_rsp_t;

endpackage

// ===== hdl/krst_mem.sv =====
module krst_mem import krst_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  krst_entry_t   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output krst_entry_t   rdata
);

	krst_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/krst_div.sv =====
module krst_div import krst_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  krst_div_req_t req,
	output krst_div_rsp_t rsp
);

	// Restoring division, one quotient bit per cycle, dividend MSB first.
	logic [127:0] num_q;
	logic [31:0]  den_q;
	logic [31:0]  rem_q;
	logic [63:0]  quot_q;
	logic         qhi_q;
	logic [6:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [32:0]  trial;
	logic [32:0]  diff;
	logic         ge;

	assign trial = {rem_q, num_q[127]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
			qhi_q  <= 1'b0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
				quot_q <= '0;
				qhi_q  <= 1'b0;
				cnt_q  <= req.wide ? 7'd127 : 7'd63;
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= ge ? diff[31:0] : trial[31:0];
				quot_q <= {quot_q[62:0], ge};
				qhi_q  <= qhi_q | quot_q[63];
				num_q  <= {num_q[126:0], 1'b0};
				cnt_q  <= cnt_q - 7'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.qhi  = qhi_q;
	assign rsp.quot = quot_q;

endmodule

// ===== hdl/krst_sqrt.sv =====
module krst_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	// Digit-by-digit square root, two radicand bits per cycle.
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] cur;
	logic [35:0] trial;

	assign cur   = {rem_q, rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'd31;
				run_q  <= 1'b1;
			end else if (run_q) begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (cur >= trial) begin
					rem_q  <= 34'(cur - trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= 34'(cur);
					root_q <= {root_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/krst_stats.sv =====
module krst_stats import krst_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  krst_stats_arg_t arg,
	output krst_stats_res_t res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MUL,
		ST_SQD,
		ST_VAR,
		ST_ROOT
	} st_t;

	st_t             state_q;
	krst_stats_arg_t arg_q;
	krst_div_req_t   div_q;
	krst_div_rsp_t   div_rsp;
	logic            sqrt_go_q;
	logic [63:0]     rad_q;
	logic            sqrt_done;
	logic [31:0]     sqrt_root;
	logic [1:0]      mstep_q;
	logic [63:0]     prod_s1;
	logic [127:0]    acc_q;
	logic [127:0]    acc_next;
	logic [127:0]    shifted;
	logic [31:0]     opa;
	logic [31:0]     opb;
	logic [63:0]     diff;
	logic [31:0]     mean_q;
	logic [31:0]     dev_q;
	logic            done_q;

	krst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_q),
		.rsp    (div_rsp)
	);

	krst_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sqrt_go_q),
		.radicand (rad_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// sum*sum from three 32x32 partial products: lo*lo, lo*hi (twice), hi*hi.
	always_comb begin
		case (mstep_q)
			2'd0: begin
				opa = arg_q.sum[31:0];
				opb = arg_q.sum[31:0];
			end
			2'd1: begin
				opa = arg_q.sum[31:0];
				opb = arg_q.sum[63:32];
			end
			default: begin
				opa = arg_q.sum[63:32];
				opb = arg_q.sum[63:32];
			end
		endcase
		case (mstep_q)
			2'd1:    shifted = {64'b0, prod_s1};
			2'd2:    shifted = {31'b0, prod_s1, 33'b0};
			2'd3:    shifted = {prod_s1, 64'b0};
			default: shifted = '0;
		endcase
		acc_next = acc_q + shifted;
		if (div_rsp.qhi || div_rsp.quot > arg_q.sumsq) begin
			diff = '0;
		end else begin
			diff = arg_q.sumsq - div_rsp.quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			arg_q     <= '0;
			div_q     <= '0;
			sqrt_go_q <= 1'b0;
			rad_q     <= '0;
			mstep_q   <= '0;
			prod_s1   <= '0;
			acc_q     <= '0;
			mean_q    <= '0;
			dev_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			div_q.go  <= 1'b0;
			sqrt_go_q <= 1'b0;
			done_q    <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						arg_q      <= arg;
						div_q.go   <= 1'b1;
						div_q.wide <= 1'b0;
						div_q.num  <= {arg.sum, 64'b0};
						div_q.den  <= arg.count;
						state_q    <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (div_rsp.done) begin
						mean_q  <= (div_rsp.quot[63:32] != '0) ? COUNT_MAX
							: div_rsp.quot[31:0];
						mstep_q <= '0;
						acc_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_s1 <= opa * opb;
					acc_q   <= acc_next;
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd3) begin
						div_q.go   <= 1'b1;
						div_q.wide <= 1'b1;
						div_q.num  <= acc_next;
						state_q    <= ST_SQD;
					end
				end
				ST_SQD: begin
					if (div_rsp.done) begin
						div_q.go   <= 1'b1;
						div_q.wide <= 1'b0;
						div_q.num  <= {diff, 64'b0};
						state_q    <= ST_VAR;
					end
				end
				ST_VAR: begin
					if (div_rsp.done) begin
						sqrt_go_q <= 1'b1;
						rad_q     <= div_rsp.quot;
						state_q   <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						dev_q   <= sqrt_root;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.mean = mean_q;
	assign res.dev  = dev_q;

endmodule

// ===== hdl/keyed_running_stats_table.sv =====
// Channel  Signals                      Direction  Moves
// cmd      cmd_valid, cmd_ready, cmd    in         one update or lookup request
// rsp      rsp_valid, rsp_ready, rsp    out        one result per request
//
// One request at a time. Its duration grows with fill, the number of occupied
// entries of its target: the key search reads one entry per cycle, then the
// shared bit-serial divider runs 64, 128 and 64 steps and the root unit 32
// steps. Reset clears the per-target fill counters but not the memory, so no
// clearing pass over the memory is needed. A new request is taken while an
// earlier result still waits on a stalled rsp channel.
`include "keyed_running_stats_table_defines.svh"

module keyed_running_stats_table import krst_pkg::*; #(
	parameter int ENTRIES = 256,
	parameter int TARGETS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  krst_cmd_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output krst_rsp_t rsp
);

	localparam int SLOTS = ENTRIES * TARGETS;
	localparam int AW    = $clog2(SLOTS);
	localparam int IW    = $clog2(ENTRIES + 1);
	localparam int TW    = (TARGETS > 1) ? $clog2(TARGETS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPD,
		S_STATS_GO,
		S_STATS_WAIT,
		S_DONE
	} state_t;

	state_t          state_q;
	logic            req_q;
	logic [31:0]     key_q;
	logic [31:0]     size_q;
	logic [31:0]     x_q;
	logic [63:0]     sqx_q;
	logic [TW-1:0]   tgt_q;
	logic [AW-1:0]   base_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   idx_s1;
	logic            pend_s1;
	logic [IW-1:0]   slot_q;
	logic            found_q;
	krst_entry_t     ent_q;
	krst_rsp_t       res_q;
	krst_rsp_t       rsp_q;
	logic            rsp_valid_q;
	logic [IW-1:0]   fill_q [TARGETS];

	logic [IW-1:0]   fill_cur;
	logic            hit_now;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	krst_entry_t     mem_wdata;
	krst_entry_t     mem_rd;
	krst_entry_t     ent_upd;
	logic [64:0]     sq_add;
	logic            cmd_fire;
	logic            stats_go;
	krst_stats_arg_t stats_arg;
	krst_stats_res_t stats_res;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign fill_cur = fill_q[tgt_q];

	// Search: one read issued per cycle, its key compared the cycle after.
	// Occupied entries of a target always sit at the front of its region,
	// since entries are taken lowest first and never released.
	assign hit_now   = pend_s1 && (mem_rd.key == key_q);
	assign mem_re    = (state_q == S_SCAN) && !hit_now && (idx_q != fill_cur);
	assign mem_raddr = base_q + AW'(idx_q);

	// Accumulate into a hit entry, or start a new one on a miss; the sum of squares saturates.
	always_comb begin
		sq_add        = {1'b0, ent_q.sumsq} + {1'b0, sqx_q};
		ent_upd       = ent_q;
		ent_upd.count = ent_q.count + 32'd1;
		ent_upd.sum   = ent_q.sum + {32'b0, x_q};
		ent_upd.sumsq = sq_add[64] ? '1 : sq_add[63:0];
		if (!found_q) begin
			ent_upd.key   = key_q;
			ent_upd.size  = size_q;
			ent_upd.count = 32'd1;
			ent_upd.sum   = {32'b0, x_q};
			ent_upd.sumsq = sqx_q;
		end
	end

	// A record request writes when it hits an unsaturated entry, or when it
	// misses and a free entry remains.
	assign mem_we = (state_q == S_UPD) && (req_q == REQ_RECORD)
		&& (found_q ? (ent_q.count != COUNT_MAX) : (fill_cur != IW'(ENTRIES)));
	assign mem_waddr = base_q + AW'(found_q ? slot_q : fill_cur);
	assign mem_wdata = ent_upd;

	krst_mem #(
		.DEPTH (SLOTS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rd)
	);

	assign stats_go        = (state_q == S_STATS_GO);
	assign stats_arg.count = ent_q.count;
	assign stats_arg.sum   = ent_q.sum;
	assign stats_arg.sumsq = ent_q.sumsq;

	krst_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (stats_go),
		.arg    (stats_arg),
		.res    (stats_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= REQ_RECORD;
			key_q       <= '0;
			size_q      <= '0;
			x_q         <= '0;
			sqx_q       <= '0;
			tgt_q       <= '0;
			base_q      <= '0;
			idx_q       <= '0;
			idx_s1      <= '0;
			pend_s1     <= 1'b0;
			slot_q      <= '0;
			found_q     <= 1'b0;
			ent_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int t = 0; t < TARGETS; t++) begin
				fill_q[t] <= '0;
			end
		end else begin
			pend_s1 <= mem_re;
			if (mem_re) begin
				idx_s1 <= idx_q;
				idx_q  <= idx_q + IW'(1);
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						req_q   <= cmd.req_type;
						key_q   <= cmd.footprint;
						size_q  <= cmd.data_size;
						x_q     <= cmd.measured;
						sqx_q   <= cmd.measured * cmd.measured;
						tgt_q   <= TW'(cmd.arch);
						base_q  <= AW'(int'(TW'(cmd.arch)) * ENTRIES);
						idx_q   <= '0;
						found_q <= 1'b0;
						res_q   <= '0;
						// A target beyond the configured tables gives an empty result.
						if (32'(cmd.arch) < TARGETS) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (hit_now) begin
						found_q <= 1'b1;
						slot_q  <= idx_s1;
						ent_q   <= mem_rd;
						state_q <= S_UPD;
					end else if (idx_q == fill_cur) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (req_q == REQ_LOOKUP) begin
						state_q <= found_q ? S_STATS_GO : S_DONE;
					end else if (found_q) begin
						// A saturated count leaves the entry as it is.
						if (mem_we) begin
							ent_q <= ent_upd;
						end
						state_q <= S_STATS_GO;
					end else if (mem_we) begin
						ent_q         <= ent_upd;
						fill_q[tgt_q] <= fill_cur + IW'(1);
						state_q       <= S_STATS_GO;
					end else begin
						res_q.table_full <= 1'b1;
						state_q          <= S_DONE;
					end
				end
				S_STATS_GO: begin
					state_q <= S_STATS_WAIT;
				end
				S_STATS_WAIT: begin
					if (stats_res.done) begin
						res_q.hit        <= 1'b1;
						res_q.mean       <= stats_res.mean;
						res_q.deviation  <= stats_res.dev;
						res_q.samples    <= ent_q.count;
						res_q.table_full <= 1'b0;
						state_q          <= S_DONE;
					end
				end
				S_DONE: begin
					// Hand over once the result register is free or drains now.
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`KRST_NEVER(a_fill_range, fill_q[tgt_q] > IW'(ENTRIES))
	`KRST_ASSERT(a_write_leads_stats, mem_we |=> state_q == S_STATS_GO)
	`KRST_ASSERT(a_full_no_hit, rsp_valid_q |-> !(rsp_q.hit && rsp_q.table_full))
	`KRST_ASSERT(a_hit_has_samples, (rsp_valid_q && rsp_q.hit) |-> rsp_q.samples != '0)
	`KRST_ASSERT(a_rsp_from_done, $rose(rsp_valid_q) |-> $past(state_q == S_DONE))

endmodule
